>>> hw/rtl/ebdg_pkg.sv
package ebdg_pkg;

  // Default internal delay width; configuration and result fields stay 32 bits wide.
  localparam int unsigned DELAY_WIDTH_DEF = 32;
  localparam int unsigned CFG_WIDTH       = 32;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned GROWTH_WIDTH    = 16;
  localparam int unsigned JITTER_WIDTH    = 8;
  localparam int unsigned SAMPLE_WIDTH    = 8;
  localparam int unsigned JFACT_WIDTH     = 10;
  localparam int unsigned STEP_WIDTH      = 16;
  localparam int unsigned OUT_WIDTH       = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FIRST_DELAY   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_DELAY     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_DELAY     = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GROWTH_FACTOR = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_JITTER_RANGE  = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT_LIMIT = 3'd5;

  // Register reset values.
  localparam logic [CFG_WIDTH-1:0]    FIRST_DELAY_RST   = 32'd1000;
  localparam logic [CFG_WIDTH-1:0]    MIN_DELAY_RST     = 32'd1000;
  localparam logic [CFG_WIDTH-1:0]    MAX_DELAY_RST     = 32'd60000;
  localparam logic [GROWTH_WIDTH-1:0] GROWTH_FACTOR_RST = 16'd512;
  localparam logic [JITTER_WIDTH-1:0] JITTER_RANGE_RST  = 8'd0;
  localparam logic [CFG_WIDTH-1:0]    TIMEOUT_LIMIT_RST = 32'd0;

  // Command codes carried by the input word.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_INCR   = 2'd1,
    CMD_EXPIRE = 2'd2
  } cmd_e;

  // Controller states.
  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_GROW_MUL   = 6'b000010,
    S_GROW_CLAMP = 6'b000100,
    S_JIT_MUL    = 6'b001000,
    S_JIT_CLAMP  = 6'b010000,
    S_DONE       = 6'b100000
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic start_load;
    logic incr_step;
    logic set_misuse;
    logic expire;
    logic mul_grow;
    logic mul_jit;
    logic nom_update;
    logic real_update;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic timed_out;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/ebdg_ctrl.sv
module ebdg_ctrl import ebdg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  dp_status_t             status_i,
  output dp_cmd_t                cmd_o
);

  ctrl_state_e state_q, state_d;

  // A new word is taken only between commands.
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (command_i)
            CMD_START: begin
              cmd_o.start_load = 1'b1;
              state_d          = S_JIT_MUL;
            end
            CMD_INCR: begin
              if (status_i.timed_out) begin
                cmd_o.set_misuse = 1'b1;
                state_d          = S_DONE;
              end else begin
                cmd_o.incr_step = 1'b1;
                state_d         = S_GROW_MUL;
              end
            end
            CMD_EXPIRE: begin
              cmd_o.expire = 1'b1;
              state_d      = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_GROW_MUL: begin
        cmd_o.mul_grow = 1'b1;
        state_d        = S_GROW_CLAMP;
      end
      S_GROW_CLAMP: begin
        cmd_o.nom_update = 1'b1;
        state_d          = S_JIT_MUL;
      end
      S_JIT_MUL: begin
        cmd_o.mul_jit = 1'b1;
        state_d       = S_JIT_CLAMP;
      end
      S_JIT_CLAMP: begin
        cmd_o.real_update = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/ebdg_datapath.sv
module ebdg_datapath import ebdg_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  input  logic [SAMPLE_WIDTH-1:0]  random_sample_i,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [OUT_WIDTH-1:0]     current_delay_o,
  output logic [OUT_WIDTH-1:0]     elapsed_total_o,
  output logic                     timed_out_o,
  output logic                     misuse_o
);

  localparam int unsigned DW = DELAY_WIDTH;
  localparam int unsigned PW = DELAY_WIDTH + GROWTH_WIDTH;
  localparam logic [DW-1:0] DMAX = {DW{1'b1}};

  // Register values above the delay maximum read as the maximum.
  function automatic logic [DW-1:0] to_delay(input logic [CFG_WIDTH-1:0] v);
    logic [DW-1:0] r;
    if (64'(v) > 64'(DMAX)) begin
      r = DMAX;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // Product scaled down by 256 and saturated to the delay maximum.
  function automatic logic [DW-1:0] sat_q8(input logic [PW-1:0] p);
    logic [DW-1:0] r;
    if (|p[PW-1:DW+8]) begin
      r = DMAX;
    end else begin
      r = p[DW+7:8];
    end
    return r;
  endfunction

  logic [CFG_WIDTH-1:0]    first_q, min_q, max_q, timeout_q;
  logic [GROWTH_WIDTH-1:0] growth_q;
  logic [JITTER_WIDTH-1:0] jrange_q;

  logic [STEP_WIDTH-1:0]   step_q;
  logic [DW-1:0]           nominal_q, real_q, elapsed_q;
  logic                    first_inc_q;
  logic                    misuse_q;
  logic [JFACT_WIDTH-1:0]  jfact_q;
  logic [PW-1:0]           prod_q;
  logic [DW-1:0]           headroom_q;
  logic                    over_q, ten_q;

  logic                    out_valid_q;
  logic [OUT_WIDTH-1:0]    out_delay_q, out_elapsed_q;
  logic                    out_to_q, out_misuse_q;

  logic [DW-1:0]           lo, hi, t_lim;
  logic                    timed_out;

  assign lo    = to_delay(min_q);
  assign hi    = to_delay(max_q);
  assign t_lim = to_delay(timeout_q);

  // Timeout is reached once the elapsed sum meets a non-zero limit.
  assign timed_out = (t_lim != '0) && (elapsed_q >= t_lim);

  assign status_o.timed_out = timed_out;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= FIRST_DELAY_RST;
      min_q     <= MIN_DELAY_RST;
      max_q     <= MAX_DELAY_RST;
      growth_q  <= GROWTH_FACTOR_RST;
      jrange_q  <= JITTER_RANGE_RST;
      timeout_q <= TIMEOUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_DELAY:   first_q   <= cfg_data_i;
        REG_MIN_DELAY:     min_q     <= cfg_data_i;
        REG_MAX_DELAY:     max_q     <= cfg_data_i;
        REG_GROWTH_FACTOR: growth_q  <= cfg_data_i[GROWTH_WIDTH-1:0];
        REG_JITTER_RANGE:  jrange_q  <= cfg_data_i[JITTER_WIDTH-1:0];
        REG_TIMEOUT_LIMIT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Jitter factor in Q8.8: 256 - r + (r * u) / 128, taken with the word.
  logic [2*SAMPLE_WIDTH-1:0] ru;
  logic [JFACT_WIDTH-1:0]    jfact_d;
  assign ru      = jrange_q * random_sample_i;
  assign jfact_d = JFACT_WIDTH'(256) - JFACT_WIDTH'(jrange_q)
                 + JFACT_WIDTH'(ru[2*SAMPLE_WIDTH-1:7]);

  // Shared multiplier: nominal delay times growth factor or jitter factor.
  logic [GROWTH_WIDTH-1:0] mul_b;
  logic [PW-1:0]           prod_d;
  assign mul_b  = cmd_i.mul_jit ? GROWTH_WIDTH'(jfact_q) : growth_q;
  assign prod_d = PW'(nominal_q) * PW'(mul_b);

  // Nominal delay after an increment, clamped to max first and then to min.
  logic [DW-1:0] grow_src, grow_hi, grow_d;
  always_comb begin
    if (first_inc_q) begin
      grow_src = (|growth_q[GROWTH_WIDTH-1:8]) ? lo : hi;
    end else begin
      grow_src = sat_q8(prod_q);
    end
    grow_hi = (grow_src > hi) ? hi : grow_src;
    grow_d  = (grow_hi < lo) ? lo : grow_hi;
  end

  // Real delay, limited to the room left before the timeout.
  logic [DW-1:0] jit_sat, real_d;
  always_comb begin
    jit_sat = sat_q8(prod_q);
    real_d  = jit_sat;
    if (ten_q) begin
      if (over_q) begin
        real_d = '0;
      end else if (jit_sat > headroom_q) begin
        real_d = headroom_q;
      end
    end
  end

  // Saturating add of the real delay to the elapsed sum.
  logic [DW:0]   sum_w;
  logic [DW-1:0] elapsed_add;
  assign sum_w       = {1'b0, elapsed_q} + {1'b0, real_q};
  assign elapsed_add = sum_w[DW] ? DMAX : sum_w[DW-1:0];

  // Backoff state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      nominal_q <= '0;
      real_q    <= '0;
      elapsed_q <= '0;
    end else begin
      if (cmd_i.start_load) begin
        step_q    <= '0;
        elapsed_q <= '0;
        nominal_q <= to_delay(first_q);
      end
      if (cmd_i.incr_step && (step_q != {STEP_WIDTH{1'b1}})) begin
        step_q <= step_q + STEP_WIDTH'(1);
      end
      if (cmd_i.expire) begin
        elapsed_q <= elapsed_add;
      end
      if (cmd_i.nom_update) begin
        nominal_q <= grow_d;
      end
      if (cmd_i.real_update) begin
        real_q <= real_d;
      end
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      jfact_q  <= jfact_d;
      misuse_q <= cmd_i.set_misuse;
    end
    if (cmd_i.incr_step) begin
      first_inc_q <= (step_q == '0);
    end
    if (cmd_i.mul_grow || cmd_i.mul_jit) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_jit) begin
      headroom_q <= t_lim - elapsed_q;
      over_q     <= (elapsed_q > t_lim);
      ten_q      <= (t_lim != '0);
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_delay_q   <= OUT_WIDTH'(real_q);
      out_elapsed_q <= OUT_WIDTH'(elapsed_q);
      out_to_q      <= timed_out;
      out_misuse_q  <= misuse_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_delay_o = out_delay_q;
  assign elapsed_total_o = out_elapsed_q;
  assign timed_out_o     = out_to_q;
  assign misuse_o        = out_misuse_q;

endmodule

>>> hw/rtl/exponential_backoff_delay_gen.sv
// Exponential backoff delay generator with jitter.
// Configuration: a write at cfg_idx_i takes cfg_data_i in the same clock edge;
// write only while no command is in flight. Registers reset to first and min
// delay 1000, max delay 60000, growth 2.0, no jitter and no timeout.
// Input channel: one word per command (start, increment, expiration) with a
// random byte for jitter; a word is taken when in_valid_i is high and
// in_stall_o is low. Output channel: one result word per command, taken when
// out_valid_o is high and out_stall_i is low.
// Steps from acceptance to the result: expiration, unused codes and an increment
// ignored after the timeout go straight to the result; start runs the jitter
// multiply and its clamp; increment runs the growth multiply and clamp, then the
// jitter multiply and clamp, on the shared delay-by-factor multiplier. The next
// word is taken in the cycle after the result is loaded, so the block does not
// take a new word before the last one's result is loaded.
// A stalled result stays in the output register; the block still takes the
// next word and works on it, and holds its new result until the register is
// free. Reset clears the state: step count and the nominal, real and elapsed
// delays read zero.
module exponential_backoff_delay_gen import ebdg_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [SAMPLE_WIDTH-1:0]  random_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [OUT_WIDTH-1:0]     current_delay_o,
  output logic [OUT_WIDTH-1:0]     elapsed_total_o,
  output logic                     timed_out_o,
  output logic                     misuse_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer for the command steps.
  ebdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Registers, multiplier, clamps and the output register.
  ebdg_datapath #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .random_sample_i (random_sample_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_delay_o (current_delay_o),
    .elapsed_total_o (elapsed_total_o),
    .timed_out_o     (timed_out_o),
    .misuse_o        (misuse_o)
  );

endmodule

>>> test/testbench.sv
module testbench import ebdg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [63:0]   DELAY_MAX      = 64'hFFFF_FFFF;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT    = 2_500_000;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_WORDS    = 50;
  localparam int unsigned LONG_RUN_WORDS = 30;
  localparam int unsigned PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] elapsed;
    logic        tmo;
    logic        mis;
  } backoff_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [CFG_WIDTH-1:0]     cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               command_i;
  logic [SAMPLE_WIDTH-1:0]  random_sample_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [OUT_WIDTH-1:0]     current_delay_o;
  logic [OUT_WIDTH-1:0]     elapsed_total_o;
  logic                     timed_out_o;
  logic                     misuse_o;

  // Local copy of the configuration and of the backoff state.
  bit [63:0] cfg_first, cfg_min, cfg_max, cfg_growth, cfg_jitter, cfg_timeout;
  bit [63:0] nom_ticks, act_ticks, elapsed_ticks;
  bit [15:0] incr_count;

  backoff_result_t pending_results[$];
  backoff_result_t want;

  int unsigned errors, results_checked, timed_out_seen;
  int unsigned cycle_count = 0;
  int unsigned n_start, n_incr, n_ignored, n_expire, n_unused;
  int unsigned stall_left = 0;
  bit          idle_on;

  exponential_backoff_delay_gen DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .random_sample_i(random_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_delay_o(current_delay_o),
    .elapsed_total_o(elapsed_total_o),
    .timed_out_o    (timed_out_o),
    .misuse_o       (misuse_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  // Output stalls: mostly short, occasionally long; no new ones start while idling is off.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: delay %0d elapsed %0d",
                                  current_delay_o, elapsed_total_o));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (timed_out_o === 1'b1) timed_out_seen++;
        if (current_delay_o !== want.delay)
          report_mismatch($sformatf("current_delay got %0d expected %0d",
                                    current_delay_o, want.delay));
        if (elapsed_total_o !== want.elapsed)
          report_mismatch($sformatf("elapsed_total got %0d expected %0d",
                                    elapsed_total_o, want.elapsed));
        if (timed_out_o !== want.tmo)
          report_mismatch($sformatf("timed_out got %b expected %b", timed_out_o, want.tmo));
        if (misuse_o !== want.mis)
          report_mismatch($sformatf("misuse got %b expected %b", misuse_o, want.mis));
      end
    end
  end

  // Delay times a Q8.8 factor, truncated and saturated to the delay width.
  function automatic bit [63:0] scale_q8(bit [63:0] x, bit [63:0] f);
    bit [63:0] p;
    p = (x * f) >> 8;
    return (p > DELAY_MAX) ? DELAY_MAX : p;
  endfunction

  function automatic bit timeout_reached();
    return cfg_timeout != 0 && elapsed_ticks >= cfg_timeout;
  endfunction

  // Jittered delay, then limited so that elapsed plus delay stays within the timeout.
  function automatic void derive_actual(bit [7:0] u);
    bit [63:0] j;
    j = 64'd256 - cfg_jitter + ((cfg_jitter * 64'(u)) >> 7);
    act_ticks = scale_q8(nom_ticks, j);
    if (cfg_timeout != 0) begin
      if (elapsed_ticks > cfg_timeout)
        act_ticks = 0;
      else if (act_ticks > cfg_timeout - elapsed_ticks)
        act_ticks = cfg_timeout - elapsed_ticks;
    end
  endfunction

  // Advance the local state by one command and queue the result it should give.
  function automatic void predict_backoff(logic [1:0] cmd, logic [7:0] u);
    backoff_result_t r;
    bit ignored;
    ignored = 1'b0;
    case (cmd)
      CMD_START: begin
        n_start++;
        incr_count    = 0;
        elapsed_ticks = 0;
        nom_ticks     = cfg_first;
        derive_actual(u);
      end
      CMD_INCR: begin
        n_incr++;
        if (timeout_reached()) begin
          ignored = 1'b1;
          n_ignored++;
        end else begin
          if (incr_count != 16'hFFFF) incr_count++;
          if (incr_count == 1)
            nom_ticks = (cfg_growth >= 256) ? cfg_min : cfg_max;
          else
            nom_ticks = scale_q8(nom_ticks, cfg_growth);
          if (nom_ticks > cfg_max) nom_ticks = cfg_max;
          if (nom_ticks < cfg_min) nom_ticks = cfg_min;
          derive_actual(u);
        end
      end
      CMD_EXPIRE: begin
        n_expire++;
        if (elapsed_ticks > DELAY_MAX - act_ticks)
          elapsed_ticks = DELAY_MAX;
        else
          elapsed_ticks = elapsed_ticks + act_ticks;
      end
      default: n_unused++;
    endcase
    r.delay   = act_ticks[31:0];
    r.elapsed = elapsed_ticks[31:0];
    r.tmo     = timeout_reached();
    r.mis     = ignored;
    pending_results.push_back(r);
  endfunction

  // Send one command word, after a random gap when idling is on.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] u);
    int unsigned gap, roll;
    gap = 0;
    if (idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90)
        gap = $urandom_range(8, 40);
      else if (roll >= 55)
        gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    random_sample_i <= u;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_backoff(cmd, u);
  endtask

  // Hold the sender until every result is in, then let the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_FIRST_DELAY:   cfg_first   = 64'(data);
      REG_MIN_DELAY:     cfg_min     = 64'(data);
      REG_MAX_DELAY:     cfg_max     = 64'(data);
      REG_GROWTH_FACTOR: cfg_growth  = 64'(data[15:0]);
      REG_JITTER_RANGE:  cfg_jitter  = 64'(data[7:0]);
      REG_TIMEOUT_LIMIT: cfg_timeout = 64'(data);
      default: ;
    endcase
  endtask

  // Rewrite all six registers once the block has gone quiet; unused upper bits get noise.
  task automatic load_config(input logic [31:0] first, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [15:0] growth,
                             input logic [7:0] jit, input logic [31:0] tmo);
    wait_idle();
    write_reg(REG_FIRST_DELAY, first);
    write_reg(REG_MIN_DELAY, lo);
    write_reg(REG_MAX_DELAY, hi);
    write_reg(REG_GROWTH_FACTOR, {16'($urandom), growth});
    write_reg(REG_JITTER_RANGE, {24'($urandom), jit});
    write_reg(REG_TIMEOUT_LIMIT, tmo);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      default: return $urandom_range(100, 20000);
    endcase
  endfunction

  function automatic logic [15:0] pick_growth();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd255;
      3: return 16'd256;
      4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(257, 1024));
    endcase
  endfunction

  function automatic logic [31:0] pick_timeout();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'd0;
      4: return 32'hFFFF_FFFF;
      5: return 32'd1;
      default: return $urandom_range(1000, 80000);
    endcase
  endfunction

  // Commands before any start act on the reset state.
  task automatic test_reset_state();
    idle_on = 1'b1;
    send_word(CMD_EXPIRE, 8'h00);
    send_word(CMD_UNUSED, 8'hFF);
    send_word(CMD_INCR, 8'($urandom_range(0, 255)));
    send_word(CMD_EXPIRE, 8'h5A);
  endtask

  // Minimum above maximum lets the minimum win; a factor below one starts at the maximum.
  task automatic test_clamp_order();
    load_config(32'd300, 32'd5000, 32'd2000, 16'd512, 8'd0, 32'd0);
    send_word(CMD_START, 8'h12);
    send_word(CMD_INCR, 8'h34);
    send_word(CMD_INCR, 8'h56);
    load_config(32'd300, 32'd1000, 32'd60000, 16'd0, 8'd0, 32'd0);
    send_word(CMD_START, 8'h78);
    send_word(CMD_INCR, 8'h9A);
    send_word(CMD_INCR, 8'hBC);
  endtask

  // Widest jitter with the extreme samples, and the largest growth factor.
  task automatic test_jitter_extremes();
    load_config(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 32'd0);
    send_word(CMD_START, 8'h00);
    send_word(CMD_START, 8'hFF);
    send_word(CMD_START, 8'hAA);
    send_word(CMD_INCR, 8'h55);
    send_word(CMD_INCR, 8'hFF);
  endtask

  // Saturating elapsed sum, clamping to the timeout, ignored increments,
  // expirations after the timeout and a timeout lowered below the elapsed sum.
  task automatic test_timeout();
    load_config(32'hFFFF_FFFF, 32'd1000, 32'd60000, 16'd256, 8'd0, 32'd0);
    send_word(CMD_START, 8'h01);
    send_word(CMD_EXPIRE, 8'h02);
    send_word(CMD_EXPIRE, 8'h03);
    load_config(32'd1000, 32'd1000, 32'd60000, 16'd512, 8'd0, 32'd2500);
    send_word(CMD_START, 8'h11);
    send_word(CMD_EXPIRE, 8'h22);
    send_word(CMD_INCR, 8'h33);
    send_word(CMD_EXPIRE, 8'h44);
    send_word(CMD_INCR, 8'h55);
    send_word(CMD_EXPIRE, 8'h66);
    send_word(CMD_INCR, 8'h77);
    send_word(CMD_EXPIRE, 8'h88);
    load_config(cfg_first[31:0], cfg_min[31:0], cfg_max[31:0], cfg_growth[15:0],
                cfg_jitter[7:0], 32'd1);
    send_word(CMD_INCR, 8'h99);
    send_word(CMD_EXPIRE, 8'hEE);
  endtask

  // A long run of increments back to back with a factor below one: the first
  // jumps to the maximum, later ones halve the delay down to the minimum.
  task automatic test_long_run();
    idle_on = 1'b0;
    load_config(32'd5000, 32'd1000, 32'd60000, 16'd128, 8'd0, 32'd0);
    send_word(CMD_START, 8'($urandom_range(0, 255)));
    repeat (LONG_RUN_WORDS) send_word(CMD_INCR, 8'($urandom_range(0, 255)));
  endtask

  // Phases of random settings, mostly start-led backoff sequences plus loose commands.
  task automatic test_random_phases();
    int unsigned sent, len, roll;
    logic [31:0] lo, hi;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      lo = pick_delay();
      hi = pick_delay();
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        lo = lo ^ hi;
        hi = lo ^ hi;
        lo = lo ^ hi;
      end
      load_config(pick_delay(), lo, hi, pick_growth(), 8'($urandom_range(0, 255)),
                  pick_timeout());
      idle_on = (phase % 3) != 2;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 85) begin
          send_word(CMD_START, 8'($urandom_range(0, 255)));
          sent++;
          len = $urandom_range(2, 14);
          repeat (len) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
              send_word(CMD_INCR, 8'($urandom_range(0, 255)));
            else if (roll < 95)
              send_word(CMD_EXPIRE, 8'($urandom_range(0, 255)));
            else
              send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            sent++;
          end
        end else begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_FIRST_DELAY;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    command_i       = CMD_START;
    random_sample_i = '0;
    idle_on         = 1'b0;
    cfg_first       = 64'(FIRST_DELAY_RST);
    cfg_min         = 64'(MIN_DELAY_RST);
    cfg_max         = 64'(MAX_DELAY_RST);
    cfg_growth      = 64'(GROWTH_FACTOR_RST);
    cfg_jitter      = 64'(JITTER_RANGE_RST);
    cfg_timeout     = 64'(TIMEOUT_LIMIT_RST);
    nom_ticks       = 0;
    act_ticks       = 0;
    elapsed_ticks   = 0;
    incr_count      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_clamp_order();
    test_jitter_extremes();
    test_timeout();
    test_long_run();
    test_random_phases();
    wait_idle();

    $display("Covered %0d starts, %0d increments (%0d ignored after timeout), %0d expirations",
             n_start, n_incr, n_ignored, n_expire);
    $display("and %0d unused codes; %0d results checked, %0d with the timeout flag set.",
             n_unused, results_checked, timed_out_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", errors, pending_results.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
